// File: hw/rtl/mono_framebuffer_draw_engine_macros.svh
// assertion macros for the framebuffer draw engine
`ifndef MONO_FRAMEBUFFER_DRAW_ENGINE_MACROS_SVH
`define MONO_FRAMEBUFFER_DRAW_ENGINE_MACROS_SVH
`ifndef SYNTH
`define MFDE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
`define MFDE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`else
`define MFDE_ASSERT_IMP(lbl, ante, cons)
`define MFDE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: hw/rtl/mfde_pkg.sv
// shared types, constants and font rom of the framebuffer draw engine
`timescale 1ns / 1ps
package mfde_pkg;
    localparam int ROWS_DEF = 64;
    localparam int COLS_DEF = 128;
    localparam int ROW_W    = 128;
    localparam int HALF_W   = 64;
    localparam int CRD_W    = 12;
    localparam int GLYPH_BLANK = 45;

    typedef logic [2:0] kind_t;
    localparam kind_t KIND_CLEAR   = 3'd0;
    localparam kind_t KIND_PIXEL   = 3'd1;
    localparam kind_t KIND_FILL    = 3'd2;
    localparam kind_t KIND_OUTLINE = 3'd3;
    localparam kind_t KIND_GLYPH   = 3'd4;
    localparam kind_t KIND_FLUSH   = 3'd5;

    typedef enum logic [1:0] {
        MODE_FILL    = 2'd0,
        MODE_OUTLINE = 2'd1,
        MODE_GLYPH   = 2'd2
    } mode_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic clear;
        logic rd_draw;
        logic wr_draw;
        logic row_inc;
        logic flush_rd;
        logic flush_load;
        logic empty_load;
        logic flush_end;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        kind_t kind;
        logic  draw_empty;
        logic  row_at_hi;
        logic  none_dirty;
        logic  row_dirty;
        logic  flush_last;
        logic  out_busy;
    } dp_sts_t;

    // 3x5 glyphs, one octal digit per row, top row first
    localparam logic [14:0] FONT [46] = '{
        15'o75557, 15'o26227, 15'o71747, 15'o71717, 15'o55711,
        15'o74717, 15'o74757, 15'o71122, 15'o75757, 15'o75717,
        15'o25755, 15'o65656, 15'o34443, 15'o65556, 15'o74747,
        15'o74744, 15'o34553, 15'o55755, 15'o72227, 15'o11152,
        15'o55655, 15'o44447, 15'o57755, 15'o65555, 15'o75557,
        15'o75744, 15'o75571, 15'o75655, 15'o34216, 15'o72222,
        15'o55557, 15'o55552, 15'o55775, 15'o55255, 15'o55222,
        15'o71247,
        15'o02020, 15'o00700, 15'o00002, 15'o22202, 15'o61202,
        15'o42124, 15'o12421, 15'o11244, 15'o02720,
        15'o00000
    };

    function automatic logic [14:0] glyph_bits(input logic [7:0] code);
        logic [5:0] idx;
        unique case (code) inside
            [8'h30:8'h39]: idx = 6'(code - 8'h30);
            [8'h41:8'h5A]: idx = 6'(code - 8'h41 + 8'd10);
            [8'h61:8'h7A]: idx = 6'(code - 8'h61 + 8'd10);
            8'h3A:         idx = 6'd36;
            8'h2D:         idx = 6'd37;
            8'h2E:         idx = 6'd38;
            8'h21:         idx = 6'd39;
            8'h3F:         idx = 6'd40;
            8'h3E:         idx = 6'd41;
            8'h3C:         idx = 6'd42;
            8'h2F:         idx = 6'd43;
            8'h2B:         idx = 6'd44;
            default:       idx = 6'(GLYPH_BLANK);
        endcase
        return FONT[idx];
    endfunction
endpackage

// File: hw/rtl/mfde_in_if.sv
// command channel interface
`timescale 1ns / 1ps
interface mfde_in_if;
    logic              valid;
    logic              ready;
    logic [2:0]        kind;
    logic signed [9:0] pos_x;
    logic signed [9:0] pos_y;
    logic [8:0]        width;
    logic [8:0]        height;
    logic              draw_on;
    logic [7:0]        char_code;
    logic              force_all;

    modport source (output valid, kind, pos_x, pos_y, width, height, draw_on,
                    char_code, force_all, input ready);
    modport sink (input valid, kind, pos_x, pos_y, width, height, draw_on,
                  char_code, force_all, output ready);
endinterface

// File: hw/rtl/mfde_out_if.sv
// row result channel interface
`timescale 1ns / 1ps
interface mfde_out_if;
    logic        valid;
    logic        ready;
    logic        row_valid;
    logic [5:0]  row_index;
    logic [63:0] left_pixels;
    logic [63:0] right_pixels;
    logic        last;

    modport source (output valid, row_valid, row_index, left_pixels, right_pixels,
                    last, input ready);
    modport sink (input valid, row_valid, row_index, left_pixels, right_pixels,
                  last, output ready);
endinterface

// File: hw/rtl/mfde_ctrl.sv
// command sequencer of the draw engine
`timescale 1ns / 1ps
module mfde_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  mfde_pkg::dp_sts_t  sts,
    output mfde_pkg::ctl_cmd_t cmd
);
    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DCHK   = 8'b0000_0010,
        S_DRD    = 8'b0000_0100,
        S_DWR    = 8'b0000_1000,
        S_FCHK   = 8'b0001_0000,
        S_FSCAN  = 8'b0010_0000,
        S_FLOAD  = 8'b0100_0000,
        S_FEMPTY = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    unique case (sts.kind)
                        mfde_pkg::KIND_CLEAR:   cmd.clear  = 1'b1;
                        mfde_pkg::KIND_PIXEL,
                        mfde_pkg::KIND_FILL,
                        mfde_pkg::KIND_OUTLINE,
                        mfde_pkg::KIND_GLYPH:   state_next = S_DCHK;
                        mfde_pkg::KIND_FLUSH:   state_next = S_FCHK;
                        default:                state_next = S_IDLE;
                    endcase
                end
            end
            S_DCHK:
            begin
                if (sts.draw_empty)
                    state_next = S_IDLE;
                else
                begin
                    cmd.rd_draw = 1'b1;
                    state_next  = S_DWR;
                end
            end
            S_DRD:
            begin
                cmd.rd_draw = 1'b1;
                state_next  = S_DWR;
            end
            S_DWR:
            begin
                cmd.wr_draw = 1'b1;
                if (sts.row_at_hi)
                    state_next = S_IDLE;
                else
                begin
                    cmd.row_inc = 1'b1;
                    state_next  = S_DRD;
                end
            end
            S_FCHK:
            begin
                state_next = sts.none_dirty ? S_FEMPTY : S_FSCAN;
            end
            S_FSCAN:
            begin
                if (!sts.row_dirty)
                    cmd.row_inc = 1'b1;
                else if (!sts.out_busy)
                begin
                    cmd.flush_rd = 1'b1;
                    state_next   = S_FLOAD;
                end
            end
            S_FLOAD:
            begin
                cmd.flush_load = 1'b1;
                if (sts.flush_last)
                begin
                    cmd.flush_end = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    cmd.row_inc = 1'b1;
                    state_next  = S_FSCAN;
                end
            end
            S_FEMPTY:
            begin
                if (!sts.out_busy)
                begin
                    cmd.empty_load = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule

// File: hw/rtl/mfde_datapath.sv
// row memory, clipping, mask generation, dirty marks and output register
`timescale 1ns / 1ps
module mfde_datapath #(
    parameter int ROWS = mfde_pkg::ROWS_DEF,
    parameter int COLS = mfde_pkg::COLS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rotate,
    input  logic [2:0]         kind,
    input  logic signed [9:0]  pos_x,
    input  logic signed [9:0]  pos_y,
    input  logic [8:0]         width,
    input  logic [8:0]         height,
    input  logic               draw_on,
    input  logic [7:0]         char_code,
    input  logic               force_all,
    input  mfde_pkg::ctl_cmd_t cmd,
    output mfde_pkg::dp_sts_t  sts,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               out_row_valid,
    output logic [5:0]         out_row_index,
    output logic [63:0]        out_left,
    output logic [63:0]        out_right,
    output logic               out_last
);
    localparam int RW = $clog2(ROWS);
    localparam int CW = mfde_pkg::CRD_W;
    localparam int RWD = mfde_pkg::ROW_W;
    localparam logic signed [CW-1:0] RMAX = CW'(ROWS - 1);

    // command registers
    mfde_pkg::mode_t        mode_reg;
    logic                   value_reg;
    logic signed [CW-1:0]   c0_reg, c1_reg, elo_reg, ehi_reg;
    logic [14:0]            glyph_reg;
    logic [RW-1:0]          hi_reg;
    logic                   empty_reg;
    logic [RW-1:0]          row_reg;

    // storage
    logic [RWD-1:0]         mem [ROWS];
    logic [ROWS-1:0]        vld_reg;
    logic [ROWS-1:0]        dirty_reg;
    logic [RWD-1:0]         rdata_reg;
    logic                   rvld_reg;

    logic                   out_valid_reg, out_rv_reg, out_last_reg;
    logic [5:0]             out_idx_reg;
    logic [RWD-1:0]         out_data_reg;

    // clipping of the incoming command
    logic signed [CW-1:0]   xs, ys, ws, hs, rlo, rhi, clo, chi, lo_c, hi_c;
    logic                   zero_sz;

    always_comb
    begin
        xs = {{(CW-10){pos_x[9]}}, pos_x};
        ys = {{(CW-10){pos_y[9]}}, pos_y};
        unique case (kind)
            mfde_pkg::KIND_PIXEL:
            begin
                ws = CW'(1);
                hs = CW'(1);
            end
            mfde_pkg::KIND_GLYPH:
            begin
                ws = CW'(3);
                hs = CW'(5);
            end
            default:
            begin
                ws = {{(CW-9){1'b0}}, width};
                hs = {{(CW-9){1'b0}}, height};
            end
        endcase
        if (rotate)
        begin
            rlo = RMAX - (xs + ws - CW'(1));
            rhi = RMAX - xs;
            clo = ys;
            chi = ys + hs - CW'(1);
        end
        else
        begin
            rlo = ys;
            rhi = ys + hs - CW'(1);
            clo = xs;
            chi = xs + ws - CW'(1);
        end
        zero_sz = (ws == '0) || (hs == '0);
        lo_c    = (rlo < 0) ? '0 : rlo;
        hi_c    = (rhi > RMAX) ? RMAX : rhi;
    end

    // latch command on transfer
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            unique case (kind)
                mfde_pkg::KIND_OUTLINE: mode_reg <= mfde_pkg::MODE_OUTLINE;
                mfde_pkg::KIND_GLYPH:   mode_reg <= mfde_pkg::MODE_GLYPH;
                default:                mode_reg <= mfde_pkg::MODE_FILL;
            endcase
            value_reg <= (kind == mfde_pkg::KIND_PIXEL || kind == mfde_pkg::KIND_FILL) ?
                         draw_on : 1'b1;
            c0_reg    <= clo;
            c1_reg    <= chi;
            elo_reg   <= rlo;
            ehi_reg   <= rhi;
            glyph_reg <= mfde_pkg::glyph_bits(char_code);
            hi_reg    <= hi_c[RW-1:0];
            empty_reg <= zero_sz || (lo_c > hi_c);
        end
    end

    // row pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            row_reg <= '0;
        else if (cmd.accept)
            row_reg <= (kind == mfde_pkg::KIND_FLUSH) ? '0 : lo_c[RW-1:0];
        else if (cmd.row_inc)
            row_reg <= row_reg + RW'(1);
    end

    // glyph row pattern and column mask
    logic signed [CW-1:0]   rs, gi, gc, off, ps;
    logic [2:0]             gr [8];
    logic [4:0]             pat5;
    logic                   edge_row, span;
    logic [RWD-1:0]         mask, old_row, new_row;

    always_comb
    begin
        rs       = {{(CW-RW){1'b0}}, row_reg};
        edge_row = (rs == elo_reg) || (rs == ehi_reg);
        gi       = rs - elo_reg;
        gc       = ehi_reg - rs;
        gr       = '{default: 3'b000};
        for (int r = 0; r < 5; r++)
            gr[r] = glyph_reg[14-3*r -: 3];
        if (rotate)
        begin
            for (int r = 0; r < 5; r++)
                pat5[4-r] = gr[r][2'(2'd2 - gc[1:0])];
        end
        else
            pat5 = {gr[gi[2:0]], 2'b00};
        mask = '0;
        for (int p = 0; p < RWD; p++)
        begin
            ps   = CW'(p);
            off  = ps - c0_reg;
            span = (ps >= c0_reg) && (ps <= c1_reg) && (p < COLS);
            unique case (mode_reg)
                mfde_pkg::MODE_OUTLINE:
                    mask[RWD-1-p] = span && (edge_row || ps == c0_reg || ps == c1_reg);
                mfde_pkg::MODE_GLYPH:
                    mask[RWD-1-p] = (p < COLS) && (off >= 0) && (off <= CW'(4)) &&
                                    pat5[3'(3'd4 - off[2:0])];
                default:
                    mask[RWD-1-p] = span;
            endcase
        end
        old_row = rvld_reg ? rdata_reg : '0;
        new_row = value_reg ? (old_row | mask) : (old_row & ~mask);
    end

    // row memory, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.wr_draw)
            mem[row_reg] <= new_row;
        if (cmd.rd_draw || cmd.flush_rd)
            rdata_reg <= mem[row_reg];
    end

    // per-row written marks and dirty marks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            rvld_reg  <= 1'b0;
            dirty_reg <= '1;
        end
        else
        begin
            if (cmd.rd_draw || cmd.flush_rd)
                rvld_reg <= vld_reg[row_reg];
            if (cmd.clear)
            begin
                vld_reg   <= '0;
                dirty_reg <= '1;
            end
            else if (cmd.accept && kind == mfde_pkg::KIND_FLUSH && force_all)
                dirty_reg <= '1;
            else if (cmd.flush_end)
                dirty_reg <= '0;
            else if (cmd.wr_draw)
            begin
                vld_reg[row_reg] <= 1'b1;
                if (mask != '0)
                    dirty_reg[row_reg] <= 1'b1;
            end
        end
    end

    // dirty rows after the current one
    logic more_dirty;

    always_comb
    begin
        more_dirty = 1'b0;
        for (int i = 0; i < ROWS; i++)
            if (dirty_reg[i] && (RW'(i) > row_reg))
                more_dirty = 1'b1;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.flush_load || cmd.empty_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.flush_load)
        begin
            out_rv_reg   <= 1'b1;
            out_idx_reg  <= 6'(row_reg);
            out_data_reg <= rvld_reg ? rdata_reg : '0;
            out_last_reg <= !more_dirty;
        end
        else if (cmd.empty_load)
        begin
            out_rv_reg   <= 1'b0;
            out_idx_reg  <= '0;
            out_data_reg <= '0;
            out_last_reg <= 1'b1;
        end
    end

    // status
    always_comb
    begin
        sts.kind       = kind;
        sts.draw_empty = empty_reg;
        sts.row_at_hi  = (row_reg == hi_reg);
        sts.none_dirty = (dirty_reg == '0);
        sts.row_dirty  = dirty_reg[row_reg];
        sts.flush_last = !more_dirty;
        sts.out_busy   = out_valid_reg;
    end

    assign out_valid     = out_valid_reg;
    assign out_row_valid = out_rv_reg;
    assign out_row_index = out_idx_reg;
    assign out_left      = out_data_reg[RWD-1:mfde_pkg::HALF_W];
    assign out_right     = out_data_reg[mfde_pkg::HALF_W-1:0];
    assign out_last      = out_last_reg;
endmodule

// File: hw/rtl/mono_framebuffer_draw_engine.sv
// draw: transfer, a clipping check that also reads the first row, a write for that row, then
// a read and a write per further row; when no clipped row is left the check ends the draw
// flush: transfer and dirty check, a scan step per clean row before the last dirty one, a read
// and an output load per dirty row; empty: a last result with no row; loads wait for a free output
// reset: pixels read as zero (per-row written marks), all rows dirty, rotate off
// a clear command is accepted in the idle state and restores the reset pixels and dirty marks, not rotate
`timescale 1ns / 1ps
`include "mono_framebuffer_draw_engine_macros.svh"
module mono_framebuffer_draw_engine #(
    parameter int ROWS = mfde_pkg::ROWS_DEF,
    parameter int COLS = mfde_pkg::COLS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    mfde_in_if.sink     cmd,
    mfde_out_if.source  rows,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    mfde_pkg::ctl_cmd_t ctl_cmd;
    mfde_pkg::dp_sts_t  dp_sts;
    logic               rotate_reg;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rotate_reg <= 1'b0;
        else if (psel && penable && pwrite && paddr == 2'd0)
            rotate_reg <= pwdata[0];
    end

    assign pready = 1'b1;
    assign prdata = {31'b0, rotate_reg};

    // sequencer
    mfde_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_ready (cmd.ready),
        .sts      (dp_sts),
        .cmd      (ctl_cmd)
    );

    // datapath
    mfde_datapath #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .rotate        (rotate_reg),
        .kind          (cmd.kind),
        .pos_x         (cmd.pos_x),
        .pos_y         (cmd.pos_y),
        .width         (cmd.width),
        .height        (cmd.height),
        .draw_on       (cmd.draw_on),
        .char_code     (cmd.char_code),
        .force_all     (cmd.force_all),
        .cmd           (ctl_cmd),
        .sts           (dp_sts),
        .out_valid     (rows.valid),
        .out_ready     (rows.ready),
        .out_row_valid (rows.row_valid),
        .out_row_index (rows.row_index),
        .out_left      (rows.left_pixels),
        .out_right     (rows.right_pixels),
        .out_last      (rows.last)
    );

    // checks
    `MFDE_ASSERT_IMP(a_load_free, ctl_cmd.flush_load || ctl_cmd.empty_load, !dp_sts.out_busy)
    `MFDE_ASSERT_IMP(a_wr_after_rd, ctl_cmd.wr_draw, $past(ctl_cmd.rd_draw))
    `MFDE_ASSERT_NEXT(a_last_ends, rows.valid && rows.ready && rows.last, !rows.valid)
endmodule
